FILE: design/segment_intersection_point_defines.svh
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_POINT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define SIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sip_pkg.sv
// Package: widths, stage counts and payload types of the segment intersection block.
`default_nettype none

package sip_pkg;

  localparam int unsigned COORD_WIDTH = 32;

  localparam int unsigned DIFF_W      = COORD_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  localparam int unsigned DET_W       = PROD_W + 1;
  localparam int unsigned NORM_W      = 2 * COORD_WIDTH + 1;
  localparam int unsigned SPLIT_W     = COORD_WIDTH + 1;
  localparam int unsigned HI_W        = NORM_W - SPLIT_W;
  localparam int unsigned LO_PROD_W   = SPLIT_W + COORD_WIDTH;
  localparam int unsigned HI_PROD_W   = HI_W + COORD_WIDTH;
  localparam int unsigned NUM_W       = 3 * COORD_WIDTH + 1;
  localparam int unsigned REM_W       = NUM_W - COORD_WIDTH;

  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned COORD_STAGES = COORD_WIDTH + 3;
  localparam int unsigned PIPE_STAGES  = FRONT_STAGES + COORD_STAGES;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DET_W-1:0]       det_t;

  typedef struct packed {
    coord_t a0x;
    coord_t a0y;
    coord_t a1x;
    coord_t a1y;
    coord_t b0x;
    coord_t b0y;
    coord_t b1x;
    coord_t b1y;
  } seg_t;

  // Per-axis data for the point: start, sign and magnitude of the A direction.
  typedef struct packed {
    coord_t                 start;
    logic                   dneg;
    logic [COORD_WIDTH-1:0] mag;
  } axis_t;

  typedef struct packed {
    logic              hit;
    logic [NORM_W-1:0] det;
    logic [NORM_W-1:0] sn;
    axis_t             ax;
    axis_t             ay;
  } front_t;

  // Divider word: partial remainder, dividend bits still to shift in, quotient so far.
  typedef struct packed {
    logic [REM_W-1:0]       rem;
    logic [COORD_WIDTH-1:0] low;
    logic [COORD_WIDTH-1:0] quo;
    logic [NORM_W-1:0]      den;
    coord_t                 start;
    logic                   dneg;
  } div_t;

  typedef struct packed {
    logic   hit;
    coord_t re;
    coord_t im;
  } res_t;

endpackage

`default_nettype wire

FILE: design/sip_in_if.sv
// Interface: input channel carrying one pair of segments per word.
`default_nettype none

interface sip_in_if
  import sip_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t a_start_re;
  coord_t a_start_im;
  coord_t a_end_re;
  coord_t a_end_im;
  coord_t b_start_re;
  coord_t b_start_im;
  coord_t b_end_re;
  coord_t b_end_im;

  modport source (
    output valid, a_start_re, a_start_im, a_end_re, a_end_im,
           b_start_re, b_start_im, b_end_re, b_end_im,
    input  ready
  );

  modport sink (
    input  valid, a_start_re, a_start_im, a_end_re, a_end_im,
           b_start_re, b_start_im, b_end_re, b_end_im,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/sip_out_if.sv
// Interface: result channel carrying hit flag and crossing point per word.
`default_nettype none

interface sip_out_if
  import sip_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t cross_re;
  coord_t cross_im;

  modport source (
    output valid, hit, cross_re, cross_im,
    input  ready
  );

  modport sink (
    input  valid, hit, cross_re, cross_im,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/segment_intersection_point.sv
// Top level: segment intersection pipeline with output register and skid buffer.
//
//   channel  dir  modport      payload
//   seg_i    in   sip_in_if    a/b start and end points, 8 x signed Q15.16
//   res_o    out  sip_out_if   hit, cross_re, cross_im (signed Q15.16)
//
// One pair of segments enters per cycle while the skid register is empty. A result
// passes through five front stages, two scaling stages, one divider stage per
// quotient bit, a rounding stage and the output register. The per-bit divider
// stages set the latency.
// Reset clears only the valid bits and the output/skid flags.
// An output stall parks one result in the skid register; the whole pipeline
// then freezes until the skid register drains, so nothing is lost or repeated.
`default_nettype none

`include "segment_intersection_point_defines.svh"

module segment_intersection_point
  import sip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sip_in_if.sink    seg_i,
  sip_out_if.source res_o
);

  seg_t   seg;
  front_t front;
  coord_t val_x, val_y;

  // Pipeline advances as a whole whenever the skid register is empty.
  logic                    en;
  logic [PIPE_STAGES-1:0]  v_d, v_q;
  logic [COORD_STAGES-1:0] hit_d, hit_q;

  res_t   pipe_res;
  logic   pipe_vld;
  logic   take;
  res_t   out_d, out_q, skid_d, skid_q;
  logic   out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;

  assign seg.a0x = seg_i.a_start_re;
  assign seg.a0y = seg_i.a_start_im;
  assign seg.a1x = seg_i.a_end_re;
  assign seg.a1y = seg_i.a_end_im;
  assign seg.b0x = seg_i.b_start_re;
  assign seg.b0y = seg_i.b_start_im;
  assign seg.b1x = seg_i.b_end_re;
  assign seg.b1y = seg_i.b_end_im;

  assign en          = !skid_vld_q;
  assign seg_i.ready = en;

  sip_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .seg_i   (seg),
    .front_o (front)
  );

  // Both axes share the determinant and the s numerator.
  sip_coord u_coord_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .det_i  (front.det),
    .sn_i   (front.sn),
    .axis_i (front.ax),
    .val_o  (val_x)
  );

  sip_coord u_coord_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .det_i  (front.det),
    .sn_i   (front.sn),
    .axis_i (front.ay),
    .val_o  (val_y)
  );

  // Valid bits ride alongside the data; the hit flag follows the point stages.
  always_comb begin
    v_d   = {v_q[PIPE_STAGES-2:0], seg_i.valid};
    hit_d = {hit_q[COORD_STAGES-2:0], front.hit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  // Zero the point on a miss.
  always_comb begin
    pipe_vld     = v_q[PIPE_STAGES-1];
    pipe_res.hit = hit_q[COORD_STAGES-1];
    pipe_res.re  = hit_q[COORD_STAGES-1] ? val_x : '0;
    pipe_res.im  = hit_q[COORD_STAGES-1] ? val_y : '0;
  end

  // Output register with one-word skid: drain skid first, else take the pipe tail.
  always_comb begin
    take       = out_vld_q && res_o.ready;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (take || !out_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (pipe_vld) begin
      if (take || !out_vld_q) begin
        out_d     = pipe_res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = pipe_res;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.hit      = out_q.hit;
  assign res_o.cross_re = out_q.re;
  assign res_o.cross_im = out_q.im;

  // The skid register only fills behind a stalled output word.
  `SIP_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q, "skid full with output empty")
  // A finished word at the pipe tail stays put while the skid register is full.
  `SIP_ASSERT_NEXT(a_tail_held, pipe_vld && skid_vld_q, v_q[PIPE_STAGES-1], "tail word lost")
  // A miss always carries a zero point.
  `SIP_ASSERT(a_miss_zero, out_vld_q && !out_q.hit |-> out_q.re == '0 && out_q.im == '0, "miss with nonzero point")

endmodule

`default_nettype wire

FILE: design/sip_front.sv
// Front pipeline: differences, cross products, determinants and the hit test.
`default_nettype none

module sip_front
  import sip_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  seg_t   seg_i,
  output front_t front_o
);

  // Stage 1: direction and offset vectors
  diff_t  dax_d, day_d, dbx_d, dby_d, wx_d, wy_d;
  diff_t  dax_q, day_q, dbx_q, dby_q, wx_q, wy_q;
  coord_t ax0_q, ay0_q;

  // Stage 2: the six cross products
  prod_t  pd1_d, pd2_d, ps1_d, ps2_d, pu1_d, pu2_d;
  prod_t  pd1_q, pd2_q, ps1_q, ps2_q, pu1_q, pu2_q;
  diff_t  absx, absy;
  axis_t  ax2_d, ay2_d, ax2_q, ay2_q;

  // Stage 3: determinant and the two numerators
  det_t   det3_d, sn3_d, un3_d, det3_q, sn3_q, un3_q;
  axis_t  ax3_q, ay3_q;

  // Stage 4: sign normalized so the determinant is nonnegative
  det_t   det4_d, sn4_d, un4_d, det4_q, sn4_q, un4_q;
  logic   detz4_d, detz4_q;
  axis_t  ax4_q, ay4_q;

  // Stage 5: interval test
  front_t front_d, front_q;

  always_comb begin
    dax_d = diff_t'(seg_i.a1x) - diff_t'(seg_i.a0x);
    day_d = diff_t'(seg_i.a1y) - diff_t'(seg_i.a0y);
    dbx_d = diff_t'(seg_i.b1x) - diff_t'(seg_i.b0x);
    dby_d = diff_t'(seg_i.b1y) - diff_t'(seg_i.b0y);
    wx_d  = diff_t'(seg_i.b0x) - diff_t'(seg_i.a0x);
    wy_d  = diff_t'(seg_i.b0y) - diff_t'(seg_i.a0y);
  end

  always_comb begin
    pd1_d = dbx_q * day_q;
    pd2_d = dax_q * dby_q;
    ps1_d = dbx_q * wy_q;
    ps2_d = dby_q * wx_q;
    pu1_d = dax_q * wy_q;
    pu2_d = day_q * wx_q;
    absx  = dax_q[DIFF_W-1] ? -dax_q : dax_q;
    absy  = day_q[DIFF_W-1] ? -day_q : day_q;
    ax2_d.start = ax0_q;
    ax2_d.dneg  = dax_q[DIFF_W-1];
    ax2_d.mag   = absx[COORD_WIDTH-1:0];
    ay2_d.start = ay0_q;
    ay2_d.dneg  = day_q[DIFF_W-1];
    ay2_d.mag   = absy[COORD_WIDTH-1:0];
  end

  always_comb begin
    det3_d = det_t'(pd1_q) - det_t'(pd2_q);
    sn3_d  = det_t'(ps1_q) - det_t'(ps2_q);
    un3_d  = det_t'(pu1_q) - det_t'(pu2_q);
  end

  // Flip all three signs when the determinant is negative.
  always_comb begin
    detz4_d = (det3_q == '0);
    det4_d  = det3_q[DET_W-1] ? -det3_q : det3_q;
    sn4_d   = det3_q[DET_W-1] ? -sn3_q  : sn3_q;
    un4_d   = det3_q[DET_W-1] ? -un3_q  : un3_q;
  end

  always_comb begin
    front_d.hit = !detz4_q &&
                  !sn4_q[DET_W-1] && (sn4_q <= det4_q) &&
                  !un4_q[DET_W-1] && (un4_q <= det4_q);
    front_d.det = det4_q[NORM_W-1:0];
    front_d.sn  = sn4_q[NORM_W-1:0];
    front_d.ax  = ax4_q;
    front_d.ay  = ay4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax_q   <= dax_d;
      day_q   <= day_d;
      dbx_q   <= dbx_d;
      dby_q   <= dby_d;
      wx_q    <= wx_d;
      wy_q    <= wy_d;
      ax0_q   <= seg_i.a0x;
      ay0_q   <= seg_i.a0y;
      pd1_q   <= pd1_d;
      pd2_q   <= pd2_d;
      ps1_q   <= ps1_d;
      ps2_q   <= ps2_d;
      pu1_q   <= pu1_d;
      pu2_q   <= pu2_d;
      ax2_q   <= ax2_d;
      ay2_q   <= ay2_d;
      det3_q  <= det3_d;
      sn3_q   <= sn3_d;
      un3_q   <= un3_d;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      det4_q  <= det4_d;
      sn4_q   <= sn4_d;
      un4_q   <= un4_d;
      detz4_q <= detz4_d;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

`default_nettype wire

FILE: design/sip_div_step.sv
// One registered restoring division step: one quotient bit per stage.
`default_nettype none

module sip_div_step
  import sip_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;
  div_t           div_d, div_q;

  always_comb begin
    trial = {div_i.rem, div_i.low[COORD_WIDTH-1]};
    diff  = trial - {1'b0, div_i.den};
    ge    = (trial >= {1'b0, div_i.den});
    div_d       = div_i;
    div_d.rem   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    div_d.low   = {div_i.low[COORD_WIDTH-2:0], 1'b0};
    div_d.quo   = {div_i.quo[COORD_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

`default_nettype wire

FILE: design/sip_coord.sv
// Point pipeline for one axis: scale, divide by the determinant, round, offset.
`default_nettype none

module sip_coord
  import sip_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NORM_W-1:0] det_i,
  input  logic [NORM_W-1:0] sn_i,
  input  axis_t             axis_i,
  output coord_t            val_o
);

  // Stage A: split product sn * |d|
  logic [LO_PROD_W-1:0]   lo_prod_d, lo_prod_q;
  logic [HI_PROD_W-1:0]   hi_prod_d, hi_prod_q;
  logic [NORM_W-1:0]      den_a_q;
  coord_t                 start_a_q;
  logic                   dneg_a_q;

  // Stage B: full dividend, loaded into the divider word
  logic [NUM_W-1:0]       num;
  div_t                   div0_d, div0_q;

  div_t                   chain [COORD_WIDTH+1];

  // Rounding stage
  logic                   up;
  logic [COORD_WIDTH-1:0] quo_d, quo_q;
  coord_t                 start_r_q;
  logic                   dneg_r_q;
  logic [COORD_WIDTH-1:0] sum;

  always_comb begin
    lo_prod_d = sn_i[SPLIT_W-1:0] * axis_i.mag;
    hi_prod_d = sn_i[NORM_W-1:SPLIT_W] * axis_i.mag;
  end

  always_comb begin
    num          = (NUM_W'(hi_prod_q) << SPLIT_W) + NUM_W'(lo_prod_q);
    div0_d.rem   = num[NUM_W-1:COORD_WIDTH];
    div0_d.low   = num[COORD_WIDTH-1:0];
    div0_d.quo   = '0;
    div0_d.den   = den_a_q;
    div0_d.start = start_a_q;
    div0_d.dneg  = dneg_a_q;
  end

  assign chain[0] = div0_q;

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_step
    sip_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .div_i (chain[k]),
      .div_o (chain[k+1])
    );
  end

  // Round half up on the remainder: twice the remainder against the divisor.
  always_comb begin
    up    = ({chain[COORD_WIDTH].rem, 1'b0} >= {1'b0, chain[COORD_WIDTH].den});
    quo_d = chain[COORD_WIDTH].quo + COORD_WIDTH'(up);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_prod_q <= lo_prod_d;
      hi_prod_q <= hi_prod_d;
      den_a_q   <= det_i;
      start_a_q <= axis_i.start;
      dneg_a_q  <= axis_i.dneg;
      div0_q    <= div0_d;
      quo_q     <= quo_d;
      start_r_q <= chain[COORD_WIDTH].start;
      dneg_r_q  <= chain[COORD_WIDTH].dneg;
    end
  end

  always_comb begin
    sum   = dneg_r_q ? (start_r_q - quo_q) : (start_r_q + quo_q);
    val_o = coord_t'(sum);
  end

endmodule

`default_nettype wire

FILE: test/segment_intersection_point_tb.sv
// Testbench for segment_intersection_point: random and directed segment pairs, checked in order.
`timescale 1ns / 100ps

module segment_intersection_point_tb
  import sip_pkg::*;
;

  // Pipeline stages plus the output register, used as a drain margin.
  localparam int LATENCY    = PIPE_STAGES + 1;
  localparam int QUIET_MAX  = 4000;
  localparam int RAND_ITEMS = 700;
  localparam int FRAC       = 16;

  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t ONE   = coord_t'(1) <<< FRAC;

  // Keeps the crossing results still owed by the block, oldest first.
  class crossing_board;
    res_t        owed_q[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // Point on A for one axis: round the offset to nearest, ties away from zero.
    function coord_t axis_point(coord_t start, logic signed [127:0] d,
                                logic signed [127:0] sn, logic signed [127:0] det);
      logic [127:0] m, num, den, q, sum;
      m   = (d < 0) ? -d : d;
      num = sn;
      den = det;
      q   = (((num * m) << 1) + den) / (den << 1);
      sum = $signed(start);
      sum = (d < 0) ? sum - q : sum + q;
      return sum[COORD_WIDTH-1:0];
    endfunction

    // Exact crossing test on wide integers, then the point when it hits.
    function res_t crossing_of(seg_t s);
      logic signed [127:0] dax, day, dbx, dby, wx, wy, det, sn, un;
      res_t r;
      r   = '0;
      dax = $signed(s.a1x) - $signed(s.a0x);
      day = $signed(s.a1y) - $signed(s.a0y);
      dbx = $signed(s.b1x) - $signed(s.b0x);
      dby = $signed(s.b1y) - $signed(s.b0y);
      wx  = $signed(s.b0x) - $signed(s.a0x);
      wy  = $signed(s.b0y) - $signed(s.a0y);
      det = dbx * day - dax * dby;
      sn  = dbx * wy - dby * wx;
      un  = dax * wy - day * wx;
      // parallel, collinear or degenerate: no hit
      if (det == 0) return r;
      if (det < 0) begin
        det = -det;
        sn  = -sn;
        un  = -un;
      end
      if (sn < 0 || sn > det || un < 0 || un > det) return r;
      r.hit = 1'b1;
      r.re  = axis_point(s.a0x, dax, sn, det);
      r.im  = axis_point(s.a0y, day, sn, det);
      return r;
    endfunction

    function void note_pair(seg_t s);
      owed_q.insert(owed_q.size(), crossing_of(s));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed: hit=%0b re=%h im=%h",
                 $time, got.hit, got.re, got.im);
        fails++;
        return;
      end
      want = owed_q.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch: expected %0b actual %0b", $time, want.hit, got.hit);
        fails++;
      end
      if (got.re !== want.re) begin
        $display("%0t: cross_re mismatch: expected %h actual %h", $time, want.re, got.re);
        fails++;
      end
      if (got.im !== want.im) begin
        $display("%0t: cross_im mismatch: expected %h actual %h", $time, want.im, got.im);
        fails++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   out_free;   // hold ready high while set

  crossing_board board = new();

  sip_in_if  seg_if ();
  sip_out_if res_if ();

  segment_intersection_point dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg_if),
    .res_o  (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 48);
  endfunction

  function automatic seg_t pair_of(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
                                   coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
    seg_t s;
    s.a0x = ax0; s.a0y = ay0; s.a1x = ax1; s.a1y = ay1;
    s.b0x = bx0; s.b0y = by0; s.b1x = bx1; s.b1y = by1;
    return s;
  endfunction

  // Coordinate drawn from full range, small values, the corners of the range, zero or all ones.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1, 5: return coord_t'($urandom);
      2:       return coord_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      3: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'(int'($urandom) >>> $urandom_range(4, 20));
    endcase
  endfunction

  // Half the pairs are built to cross near a common point; the rest parallel,
  // sharing an endpoint, or plain noise.
  function automatic seg_t random_pair();
    seg_t s;
    int kind, cx, cy, dx, dy, ex, ey, m1, m2, n1, n2, k;
    kind = $urandom_range(0, 99);
    cx = int'($urandom) >>> $urandom_range(1, 16);
    cy = int'($urandom) >>> $urandom_range(1, 16);
    dx = int'($urandom) >>> $urandom_range(4, 24);
    dy = int'($urandom) >>> $urandom_range(4, 24);
    ex = int'($urandom) >>> $urandom_range(4, 24);
    ey = int'($urandom) >>> $urandom_range(4, 24);
    m1 = $urandom_range(0, 3);
    m2 = $urandom_range(0, 3);
    n1 = $urandom_range(0, 3);
    n2 = $urandom_range(0, 3);
    if (kind < 50) begin
      s = pair_of(coord_t'(cx - dx * m1), coord_t'(cy - dy * m1),
                  coord_t'(cx + dx * m2), coord_t'(cy + dy * m2),
                  coord_t'(cx - ex * n1), coord_t'(cy - ey * n1),
                  coord_t'(cx + ex * n2), coord_t'(cy + ey * n2));
      // nudge an end by one LSB now and then to land next to the boundary
      if ($urandom_range(0, 3) == 0) s.a1x = s.a1x + coord_t'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 3) == 0) s.b1y = s.b1y + coord_t'($urandom_range(0, 2)) - 1;
    end else if (kind < 65) begin
      k = int'($urandom_range(0, 4)) - 2;
      s = pair_of(coord_t'(cx), coord_t'(cy), coord_t'(cx + dx), coord_t'(cy + dy),
                  '0, '0, '0, '0);
      if ($urandom_range(0, 1) == 0) begin
        s.b0x = coord_t'(cx + dx * n1);
        s.b0y = coord_t'(cy + dy * n1);
      end else begin
        s.b0x = coord_t'(cx + ex);
        s.b0y = coord_t'(cy + ey);
      end
      s.b1x = coord_t'(int'(s.b0x) + dx * k);
      s.b1y = coord_t'(int'(s.b0y) + dy * k);
    end else if (kind < 72) begin
      s = pair_of(coord_t'(cx - dx), coord_t'(cy - dy), coord_t'(cx + dx), coord_t'(cy),
                  coord_t'(cx + ex), coord_t'(cy + ey), coord_t'(cx - ex), coord_t'(cy + dy));
      case ($urandom_range(0, 3))
        0: begin s.b0x = s.a0x; s.b0y = s.a0y; end
        1: begin s.b0x = s.a1x; s.b0y = s.a1y; end
        2: begin s.b1x = s.a0x; s.b1y = s.a0y; end
        default: begin s.b1x = s.a1x; s.b1y = s.a1y; end
      endcase
    end else begin
      s = pair_of(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    return s;
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_pair(input seg_t s);
    seg_if.valid      <= 1'b1;
    seg_if.a_start_re <= s.a0x;
    seg_if.a_start_im <= s.a0y;
    seg_if.a_end_re   <= s.a1x;
    seg_if.a_end_im   <= s.a1y;
    seg_if.b_start_re <= s.b0x;
    seg_if.b_start_im <= s.b0y;
    seg_if.b_end_re   <= s.b1x;
    seg_if.b_end_im   <= s.b1y;
    do @(posedge clk); while (!seg_if.ready);
  endtask

  task automatic hold_off(input int n);
    seg_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come out.
  task automatic wait_drained();
    seg_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Sink side: ready high for a burst, then a random stall unless held free.
  initial begin : ready_gen
    int n;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      n = gap_len();
      if (!out_free && n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Note accepted words, check accepted results, and bail out if the
  // handshakes go quiet for too long.
  always @(posedge clk) begin : monitor
    seg_t s;
    res_t got;
    int   quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (seg_if.valid && seg_if.ready) begin
        s.a0x = seg_if.a_start_re; s.a0y = seg_if.a_start_im;
        s.a1x = seg_if.a_end_re;   s.a1y = seg_if.a_end_im;
        s.b0x = seg_if.b_start_re; s.b0y = seg_if.b_start_im;
        s.b1x = seg_if.b_end_re;   s.b1y = seg_if.b_end_im;
        board.note_pair(s);
        quiet = 0;
      end
      if (res_if.valid && res_if.ready) begin
        got.hit = res_if.hit;
        got.re  = res_if.cross_re;
        got.im  = res_if.cross_im;
        board.check_result(got);
        quiet = 0;
      end
      if (quiet >= QUIET_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    bit in_free;
    out_free          = 1'b0;
    rst_n             = 1'b0;
    seg_if.valid      <= 1'b0;
    seg_if.a_start_re <= '0;
    seg_if.a_start_im <= '0;
    seg_if.a_end_re   <= '0;
    seg_if.a_end_im   <= '0;
    seg_if.b_start_re <= '0;
    seg_if.b_start_im <= '0;
    seg_if.b_end_re   <= '0;
    seg_if.b_end_im   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain crossing, then the same pair swapped so det flips sign
    send_pair(pair_of(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE));
    send_pair(pair_of(-ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE));
    // parallel, collinear overlap, degenerate A, both degenerate
    send_pair(pair_of('0, '0, ONE, '0, '0, ONE, ONE, ONE));
    send_pair(pair_of('0, '0, 2 * ONE, '0, ONE, '0, 3 * ONE, '0));
    send_pair(pair_of(ONE, ONE, ONE, ONE, '0, '0, 2 * ONE, 2 * ONE));
    send_pair(pair_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    // touching: s at 0, s at 1, u at 0, u at 1
    send_pair(pair_of('0, '0, ONE, '0, '0, -ONE, '0, ONE));
    send_pair(pair_of('0, '0, ONE, '0, ONE, -ONE, ONE, ONE));
    send_pair(pair_of('0, '0, 2 * ONE, '0, ONE, '0, ONE, ONE));
    send_pair(pair_of('0, '0, 2 * ONE, '0, ONE, ONE, ONE, '0));
    // lines cross outside A, then outside B
    send_pair(pair_of('0, '0, ONE, '0, 2 * ONE, -ONE, 2 * ONE, ONE));
    send_pair(pair_of('0, '0, 2 * ONE, '0, ONE, ONE, ONE, 2 * ONE));
    // half-LSB offsets: round away from zero in both directions
    send_pair(pair_of('0, '0, coord_t'(1), '0, '0, '1, coord_t'(1), coord_t'(1)));
    send_pair(pair_of('0, '0, '1, '0, '0, '1, '1, coord_t'(1)));
    // corners of the coordinate range
    send_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
    send_pair(pair_of(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN));
    send_pair(pair_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    send_pair(pair_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_pair(pair_of('0, '0, '0, '0, '0, '0, '0, '0));
    send_pair(pair_of('1, '1, '1, '1, '1, '1, '1, '1));
    send_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN));
    send_pair(pair_of(C_MAX, C_MAX, C_MIN, C_MAX, '0, C_MIN, '0, C_MAX));

    // let the pipe run dry before the random part
    wait_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // back-to-back stretch with both sides free of gaps
      in_free  = (i >= 200 && i < 300);
      out_free = in_free;
      if (i == 450) wait_drained();
      send_pair(random_pair());
      n = gap_len();
      if (!in_free && n > 0) hold_off(n);
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
